[rtl/ccc_pkg.sv]
package ccc_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int COORD_W       = 20;
   localparam int RAD_W         = 19;
   localparam int SPACING_W     = 17;
   localparam int COUNT_W       = 7;
   localparam int QCNT_W        = 32;
   localparam int MAX_OBSTACLES = 64;
   localparam int OBS_AW        = $clog2(MAX_OBSTACLES);
   localparam int MAX_SAMPLES   = 4096;
   localparam int MIN_SAMPLES   = 2;
   localparam int SAMP_W        = $clog2(MAX_SAMPLES + 1);

   // point coordinates and multiplier operands
   localparam int PT_W   = COORD_W + 2;
   localparam int PROD_W = 2 * PT_W;
   localparam int ACC_W  = PROD_W + 1;

   localparam int DIV_NW = SAMP_W + COORD_W + 1;
   localparam int DIV_DW = SPACING_W;
   localparam int DIV_CW = $clog2(DIV_NW + 1);

   localparam int SQRT_IW = PROD_W;
   localparam int SQRT_OW = SQRT_IW / 2;
   localparam int SQRT_CW = $clog2(SQRT_OW + 1);

   localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(655);
   localparam logic signed [PT_W-1:0] COORD_ONE  = PT_W'(1 << FRAC_BITS);
   localparam logic [QCNT_W-1:0] QCNT_MAX         = '1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_POINT = 2'd2,
      OP_EDGE  = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_E1,
      S_E2,
      S_E3,
      S_SQ_GO,
      S_SQ_WAIT,
      S_SD_GO,
      S_SD_WAIT,
      S_PMX,
      S_PDX,
      S_PWX,
      S_PMY,
      S_PDY,
      S_PWY,
      S_CHECK,
      S_ORD,
      S_OM1,
      S_OM2,
      S_OM3,
      S_OCMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [RAD_W-1:0]          radius;
   } obstacle_type;

endpackage

[rtl/ccc_req_if.sv]
interface ccc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic signed [ccc_pkg::COORD_W-1:0]   x_a;
   logic signed [ccc_pkg::COORD_W-1:0]   y_a;
   logic signed [ccc_pkg::COORD_W-1:0]   x_b;
   logic signed [ccc_pkg::COORD_W-1:0]   y_b;
   logic [ccc_pkg::RAD_W-1:0]            radius;

   modport source (output valid, opcode, x_a, y_a, x_b, y_b, radius, input ready);
   modport sink (input valid, opcode, x_a, y_a, x_b, y_b, radius, output ready);
endinterface

[rtl/ccc_rsp_if.sv]
interface ccc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic                          collision_free;
   logic [ccc_pkg::COUNT_W-1:0]   obstacles_held;
   logic [ccc_pkg::QCNT_W-1:0]    queries_so_far;

   modport source (output valid, status, collision_free, obstacles_held, queries_so_far,
                   input ready);
   modport sink (input valid, status, collision_free, obstacles_held, queries_so_far,
                 output ready);
endinterface

[rtl/ccc_ram.sv]
module ccc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/ccc_div.sv]
module ccc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ccc_pkg::DIV_NW-1:0]  num,
   input  logic [ccc_pkg::DIV_DW-1:0]  den,
   output logic                        done,
   output logic [ccc_pkg::DIV_NW-1:0]  quot
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [ccc_pkg::DIV_CW-1:0]  cnt_ff, cnt_in;
   logic [ccc_pkg::DIV_NW-1:0]  quo_ff, quo_in;
   logic [ccc_pkg::DIV_DW-1:0]  rem_ff, rem_in;
   logic [ccc_pkg::DIV_DW-1:0]  den_ff, den_in;
   logic [ccc_pkg::DIV_DW:0]    rem_t;
   logic                        ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_t   = {rem_ff, quo_ff[ccc_pkg::DIV_NW-1]};
      ge      = rem_t >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ccc_pkg::DIV_CW'(ccc_pkg::DIV_NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? ccc_pkg::DIV_DW'(rem_t - {1'b0, den_ff})
                     : ccc_pkg::DIV_DW'(rem_t);
         quo_in = {quo_ff[ccc_pkg::DIV_NW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ccc_pkg::DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/ccc_sqrt.sv]
module ccc_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ccc_pkg::SQRT_IW-1:0]  radicand,
   output logic                         done,
   output logic [ccc_pkg::SQRT_OW-1:0]  root
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ccc_pkg::SQRT_CW-1:0]  cnt_ff, cnt_in;
   logic [ccc_pkg::SQRT_IW-1:0]  rad_ff, rad_in;
   logic [ccc_pkg::SQRT_OW+2:0]  rem_ff, rem_in;
   logic [ccc_pkg::SQRT_OW-1:0]  root_ff, root_in;
   logic [ccc_pkg::SQRT_OW+2:0]  rem_t;
   logic [ccc_pkg::SQRT_OW+2:0]  trial;
   logic                         ge;

   // digit-by-digit square root, two radicand bits per cycle
   always_comb begin
      rem_t   = {rem_ff[ccc_pkg::SQRT_OW:0], rad_ff[ccc_pkg::SQRT_IW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = rem_t >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ccc_pkg::SQRT_CW'(ccc_pkg::SQRT_OW);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_t - trial : rem_t;
         root_in = {root_ff[ccc_pkg::SQRT_OW-2:0], ge};
         rad_in  = {rad_ff[ccc_pkg::SQRT_IW-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == ccc_pkg::SQRT_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[rtl/circle_obstacle_collision_checker_core.sv]
// Channel   Dir  Handshake     Payload
// req_chan  in   valid/ready   opcode, x_a, y_a, x_b, y_b, radius
// rsp_chan  out  valid/ready   status, collision_free, obstacles_held, queries_so_far
// csr_*     in   write enable  sample_spacing (17 bits)
//
// A clear or load request goes straight to the done state; a point request checks the square,
// then each held obstacle in turn (RAM read, three products on the shared multiplier, compare).
// An edge request adds the length and its square root, the sample count divide (skipped at
// zero spacing) and, per sample point, two position divides ahead of the point check.
// Reset is synchronous; it empties the table, zeroes the query count, reloads spacing.
// Input is ready again once a request finishes, even while its response waits.
module circle_obstacle_collision_checker_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ccc_pkg::SPACING_W-1:0]   csr_write_data,
   ccc_req_if.sink                         req_chan,
   ccc_rsp_if.source                       rsp_chan
);

   ccc_pkg::state_type                   state_ff, state_in;
   logic [ccc_pkg::SPACING_W-1:0]        spacing_ff, spacing_in;
   logic [ccc_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic [ccc_pkg::QCNT_W-1:0]           qcnt_ff, qcnt_in;
   ccc_pkg::opcode_type                  op_ff, op_in;
   logic signed [ccc_pkg::COORD_W-1:0]   xa_ff, xa_in, ya_ff, ya_in;
   logic signed [ccc_pkg::COORD_W:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ccc_pkg::PT_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic [ccc_pkg::SAMP_W-1:0]           samples_ff, samples_in, idx_ff, idx_in;
   logic [ccc_pkg::OBS_AW-1:0]           k_ff, k_in;
   logic signed [ccc_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [ccc_pkg::ACC_W-1:0]            acc_ff, acc_in;
   logic                                 neg_ff, neg_in;
   logic                                 res_status_ff, res_status_in;
   logic                                 res_free_ff, res_free_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_status_ff, rsp_status_in;
   logic                                 rsp_free_ff, rsp_free_in;
   logic [ccc_pkg::COUNT_W-1:0]          rsp_held_ff, rsp_held_in;
   logic [ccc_pkg::QCNT_W-1:0]           rsp_qcnt_ff, rsp_qcnt_in;

   logic                                 accept;
   ccc_pkg::opcode_type                  req_op;
   logic                                 slot_free;
   logic                                 table_full;
   logic signed [ccc_pkg::PT_W-1:0]      mul_a, mul_b;
   logic                                 mul_en;
   logic [ccc_pkg::PROD_W-1:0]           prod_mag;
   logic signed [ccc_pkg::PT_W-1:0]      quo_s, delta;
   logic [ccc_pkg::SAMP_W-1:0]           samples_sat;
   logic                                 pt_done, pt_ok, walk_on;
   logic                                 oob;

   logic                                 div_start, div_done;
   logic [ccc_pkg::DIV_NW-1:0]           div_num, div_quot;
   logic [ccc_pkg::DIV_DW-1:0]           div_den;
   logic                                 sqrt_start, sqrt_done;
   logic [ccc_pkg::SQRT_OW-1:0]          sqrt_root;

   logic                                 ram_we, ram_re;
   ccc_pkg::obstacle_type                ram_wdata, obs;

   assign accept     = req_chan.valid && req_chan.ready;
   assign req_op     = ccc_pkg::opcode_type'(req_chan.opcode);
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign table_full = count_ff >= ccc_pkg::COUNT_W'(ccc_pkg::MAX_OBSTACLES);

   assign req_chan.ready          = state_ff == ccc_pkg::S_IDLE;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.collision_free = rsp_free_ff;
   assign rsp_chan.obstacles_held = rsp_held_ff;
   assign rsp_chan.queries_so_far = rsp_qcnt_ff;

   assign ram_we    = accept && req_op == ccc_pkg::OP_LOAD && !table_full;
   assign ram_wdata = '{x: req_chan.x_a, y: req_chan.y_a, radius: req_chan.radius};

   ccc_ram #(
      .WIDTH ($bits(ccc_pkg::obstacle_type)),
      .DEPTH (ccc_pkg::MAX_OBSTACLES)
   ) u_obs_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ccc_pkg::OBS_AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (k_ff),
      .rd_data (obs)
   );

   ccc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   ccc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff[ccc_pkg::SQRT_IW-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // magnitude and sign of the truncating quotient
   assign prod_mag = prod_ff[ccc_pkg::PROD_W-1] ? ccc_pkg::PROD_W'(-prod_ff)
                                                : ccc_pkg::PROD_W'(prod_ff);
   assign quo_s    = $signed({1'b0, div_quot[ccc_pkg::PT_W-2:0]});
   assign delta    = neg_ff ? -quo_s : quo_s;

   always_comb begin
      if (div_quot > ccc_pkg::DIV_NW'(ccc_pkg::MAX_SAMPLES)) begin
         samples_sat = ccc_pkg::SAMP_W'(ccc_pkg::MAX_SAMPLES);
      end else if (div_quot < ccc_pkg::DIV_NW'(ccc_pkg::MIN_SAMPLES)) begin
         samples_sat = ccc_pkg::SAMP_W'(ccc_pkg::MIN_SAMPLES);
      end else begin
         samples_sat = div_quot[ccc_pkg::SAMP_W-1:0];
      end
   end

   // outcome of the point under test
   assign oob = px_ff < 0 || px_ff > ccc_pkg::COORD_ONE
             || py_ff < 0 || py_ff > ccc_pkg::COORD_ONE;

   always_comb begin
      pt_done = 1'b0;
      pt_ok   = 1'b0;
      case (state_ff)
         ccc_pkg::S_CHECK: begin
            if (oob) begin
               pt_done = 1'b1;
            end else if (count_ff == '0) begin
               pt_done = 1'b1;
               pt_ok   = 1'b1;
            end
         end
         ccc_pkg::S_OCMP: begin
            if (acc_ff <= ccc_pkg::ACC_W'(unsigned'(prod_ff))) begin
               pt_done = 1'b1;
            end else if (ccc_pkg::COUNT_W'(k_ff) + 1'b1 == count_ff) begin
               pt_done = 1'b1;
               pt_ok   = 1'b1;
            end
         end
         default: begin
            pt_done = 1'b0;
         end
      endcase
   end

   assign walk_on = pt_ok && op_ff == ccc_pkg::OP_EDGE && idx_ff != samples_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccc_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  ccc_pkg::OP_POINT: state_in = ccc_pkg::S_CHECK;
                  ccc_pkg::OP_EDGE:  state_in = ccc_pkg::S_E1;
                  default:           state_in = ccc_pkg::S_DONE;
               endcase
            end
         end
         ccc_pkg::S_E1:    state_in = ccc_pkg::S_E2;
         ccc_pkg::S_E2:    state_in = ccc_pkg::S_E3;
         ccc_pkg::S_E3:    state_in = ccc_pkg::S_SQ_GO;
         ccc_pkg::S_SQ_GO: state_in = ccc_pkg::S_SQ_WAIT;
         ccc_pkg::S_SQ_WAIT: begin
            if (sqrt_done) begin
               state_in = (spacing_ff == '0) ? ccc_pkg::S_PMX : ccc_pkg::S_SD_GO;
            end
         end
         ccc_pkg::S_SD_GO: state_in = ccc_pkg::S_SD_WAIT;
         ccc_pkg::S_SD_WAIT: begin
            if (div_done) begin
               state_in = ccc_pkg::S_PMX;
            end
         end
         ccc_pkg::S_PMX: state_in = ccc_pkg::S_PDX;
         ccc_pkg::S_PDX: state_in = ccc_pkg::S_PWX;
         ccc_pkg::S_PWX: begin
            if (div_done) begin
               state_in = ccc_pkg::S_PMY;
            end
         end
         ccc_pkg::S_PMY: state_in = ccc_pkg::S_PDY;
         ccc_pkg::S_PDY: state_in = ccc_pkg::S_PWY;
         ccc_pkg::S_PWY: begin
            if (div_done) begin
               state_in = ccc_pkg::S_CHECK;
            end
         end
         ccc_pkg::S_CHECK, ccc_pkg::S_OCMP: begin
            if (pt_done) begin
               state_in = walk_on ? ccc_pkg::S_PMX : ccc_pkg::S_DONE;
            end else begin
               state_in = ccc_pkg::S_ORD;
            end
         end
         ccc_pkg::S_ORD: state_in = ccc_pkg::S_OM1;
         ccc_pkg::S_OM1: state_in = ccc_pkg::S_OM2;
         ccc_pkg::S_OM2: state_in = ccc_pkg::S_OM3;
         ccc_pkg::S_OM3: state_in = ccc_pkg::S_OCMP;
         ccc_pkg::S_DONE: begin
            if (slot_free) begin
               state_in = ccc_pkg::S_IDLE;
            end
         end
         default: state_in = ccc_pkg::S_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      spacing_in    = csr_write_enable ? csr_write_data : spacing_ff;
      count_in      = count_ff;
      qcnt_in       = qcnt_ff;
      op_in         = op_ff;
      xa_in         = xa_ff;
      ya_in         = ya_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      samples_in    = samples_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      res_status_in = res_status_ff;
      res_free_in   = res_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_qcnt_in   = rsp_qcnt_ff;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      div_start     = 1'b0;
      div_num       = ccc_pkg::DIV_NW'(prod_mag);
      div_den       = ccc_pkg::DIV_DW'(samples_ff);
      sqrt_start    = 1'b0;
      ram_re        = 1'b0;

      case (state_ff)
         ccc_pkg::S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               xa_in         = req_chan.x_a;
               ya_in         = req_chan.y_a;
               dx_in         = (ccc_pkg::COORD_W+1)'(req_chan.x_b)
                             - (ccc_pkg::COORD_W+1)'(req_chan.x_a);
               dy_in         = (ccc_pkg::COORD_W+1)'(req_chan.y_b)
                             - (ccc_pkg::COORD_W+1)'(req_chan.y_a);
               px_in         = ccc_pkg::PT_W'(req_chan.x_a);
               py_in         = ccc_pkg::PT_W'(req_chan.y_a);
               res_status_in = 1'b0;
               res_free_in   = 1'b0;
               case (req_op)
                  ccc_pkg::OP_CLEAR: count_in = '0;
                  ccc_pkg::OP_LOAD: begin
                     if (table_full) begin
                        res_status_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: count_in = count_ff;
               endcase
            end
         end
         ccc_pkg::S_E1: begin
            mul_en = 1'b1;
            mul_a  = ccc_pkg::PT_W'(dx_ff);
            mul_b  = ccc_pkg::PT_W'(dx_ff);
         end
         ccc_pkg::S_E2: begin
            acc_in = ccc_pkg::ACC_W'(unsigned'(prod_ff));
            mul_en = 1'b1;
            mul_a  = ccc_pkg::PT_W'(dy_ff);
            mul_b  = ccc_pkg::PT_W'(dy_ff);
         end
         ccc_pkg::S_E3: begin
            acc_in = acc_ff + ccc_pkg::ACC_W'(unsigned'(prod_ff));
         end
         ccc_pkg::S_SQ_GO: sqrt_start = 1'b1;
         ccc_pkg::S_SQ_WAIT: begin
            if (sqrt_done) begin
               samples_in = ccc_pkg::SAMP_W'(ccc_pkg::MAX_SAMPLES);
               idx_in     = '0;
            end
         end
         ccc_pkg::S_SD_GO: begin
            div_start = 1'b1;
            div_num   = ccc_pkg::DIV_NW'(sqrt_root) + ccc_pkg::DIV_NW'(spacing_ff)
                      - ccc_pkg::DIV_NW'(1);
            div_den   = spacing_ff;
         end
         ccc_pkg::S_SD_WAIT: begin
            if (div_done) begin
               samples_in = samples_sat;
               idx_in     = '0;
            end
         end
         ccc_pkg::S_PMX, ccc_pkg::S_PMY: begin
            mul_en = 1'b1;
            mul_a  = ccc_pkg::PT_W'($signed({1'b0, idx_ff}));
            mul_b  = (state_ff == ccc_pkg::S_PMX) ? ccc_pkg::PT_W'(dx_ff)
                                                  : ccc_pkg::PT_W'(dy_ff);
         end
         ccc_pkg::S_PDX, ccc_pkg::S_PDY: begin
            div_start = 1'b1;
            neg_in    = prod_ff[ccc_pkg::PROD_W-1];
         end
         ccc_pkg::S_PWX: begin
            if (div_done) begin
               px_in = ccc_pkg::PT_W'(xa_ff) + delta;
            end
         end
         ccc_pkg::S_PWY: begin
            if (div_done) begin
               py_in = ccc_pkg::PT_W'(ya_ff) + delta;
            end
         end
         ccc_pkg::S_CHECK: begin
            if (qcnt_ff != ccc_pkg::QCNT_MAX) begin
               qcnt_in = qcnt_ff + 1'b1;
            end
            k_in = '0;
         end
         ccc_pkg::S_ORD: ram_re = 1'b1;
         ccc_pkg::S_OM1: begin
            mul_en = 1'b1;
            mul_a  = px_ff - ccc_pkg::PT_W'(obs.x);
            mul_b  = px_ff - ccc_pkg::PT_W'(obs.x);
         end
         ccc_pkg::S_OM2: begin
            acc_in = ccc_pkg::ACC_W'(unsigned'(prod_ff));
            mul_en = 1'b1;
            mul_a  = py_ff - ccc_pkg::PT_W'(obs.y);
            mul_b  = py_ff - ccc_pkg::PT_W'(obs.y);
         end
         ccc_pkg::S_OM3: begin
            acc_in = acc_ff + ccc_pkg::ACC_W'(unsigned'(prod_ff));
            mul_en = 1'b1;
            mul_a  = ccc_pkg::PT_W'($signed({1'b0, obs.radius}));
            mul_b  = ccc_pkg::PT_W'($signed({1'b0, obs.radius}));
         end
         ccc_pkg::S_OCMP: begin
            k_in = k_ff + 1'b1;
         end
         ccc_pkg::S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_free_in   = res_free_ff;
               rsp_held_in   = count_ff;
               rsp_qcnt_in   = qcnt_ff;
            end
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase

      // settle the point: finish the request or step to the next sample
      if (pt_done) begin
         res_free_in = pt_ok;
         if (walk_on) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   assign prod_in = mul_en ? mul_a * mul_b : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccc_pkg::S_IDLE;
         spacing_ff   <= ccc_pkg::SPACING_RESET;
         count_ff     <= '0;
         qcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spacing_ff   <= spacing_in;
         count_ff     <= count_in;
         qcnt_ff      <= qcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      xa_ff         <= xa_in;
      ya_ff         <= ya_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      samples_ff    <= samples_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      neg_ff        <= neg_in;
      res_status_ff <= res_status_in;
      res_free_ff   <= res_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_held_ff   <= rsp_held_in;
      rsp_qcnt_ff   <= rsp_qcnt_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ccc_pkg::COUNT_W'(ccc_pkg::MAX_OBSTACLES))
      else $error("obstacle count beyond table depth");

   a_qcnt_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> qcnt_ff >= $past(qcnt_ff))
      else $error("query count went down");

   a_samples_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ccc_pkg::S_PMX |->
         samples_ff >= ccc_pkg::SAMP_W'(ccc_pkg::MIN_SAMPLES)
         && samples_ff <= ccc_pkg::SAMP_W'(ccc_pkg::MAX_SAMPLES)
         && idx_ff <= samples_ff)
      else $error("sample index out of range");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ccc_pkg::S_SD_WAIT || state_ff == ccc_pkg::S_PWX
                   || state_ff == ccc_pkg::S_PWY)
      else $error("divider finished outside a wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ccc_pkg::S_DONE)
      else $error("response raised outside the done state");

endmodule

[tb/tb_circle_obstacle_collision_checker_core.sv]
`timescale 1ns / 100ps

module tb_circle_obstacle_collision_checker_core;

   typedef struct {
      ccc_pkg::opcode_type                op;
      logic signed [ccc_pkg::COORD_W-1:0] xa;
      logic signed [ccc_pkg::COORD_W-1:0] ya;
      logic signed [ccc_pkg::COORD_W-1:0] xb;
      logic signed [ccc_pkg::COORD_W-1:0] yb;
      logic [ccc_pkg::RAD_W-1:0]          radius;
   } request_type;

   typedef struct {
      logic                        status;
      logic                        collision_free;
      logic [ccc_pkg::COUNT_W-1:0] obstacles_held;
      logic [ccc_pkg::QCNT_W-1:0]  queries_so_far;
   } outcome_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [ccc_pkg::SPACING_W-1:0] csr_write_data;

   ccc_req_if req_bus ();
   ccc_rsp_if rsp_bus ();

   circle_obstacle_collision_checker_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   request_type request_q[$];
   outcome_type outcome_q[$];
   request_type cur_req;
   bit          failed;
   int          burst_left;
   int          gap_left;
   int          ready_left;
   bit          ready_mode;
   int          gen_count;

   // shadow of the obstacle table and counters
   logic signed [ccc_pkg::COORD_W-1:0] obs_x [ccc_pkg::MAX_OBSTACLES];
   logic signed [ccc_pkg::COORD_W-1:0] obs_y [ccc_pkg::MAX_OBSTACLES];
   logic [ccc_pkg::RAD_W-1:0]          obs_r [ccc_pkg::MAX_OBSTACLES];
   int                                 held_count;
   logic [ccc_pkg::QCNT_W-1:0]         query_total;
   logic [ccc_pkg::SPACING_W-1:0]      spacing;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit probe_point(longint px, longint py);
      longint          one;
      longint          ddx;
      longint          ddy;
      longint unsigned d2;
      longint unsigned r2;
      one = longint'(1) << ccc_pkg::FRAC_BITS;
      if (query_total != ccc_pkg::QCNT_MAX) query_total++;
      if (px < 0 || px > one || py < 0 || py > one) return 1'b0;
      for (int k = 0; k < held_count; k++) begin
         ddx = px - longint'(obs_x[k]);
         ddy = py - longint'(obs_y[k]);
         d2 = ddx * ddx + ddy * ddy;
         r2 = longint'(obs_r[k]) * longint'(obs_r[k]);
         if (d2 <= r2) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit walk_edge(longint x0, longint y0, longint x1, longint y1);
      longint          dx;
      longint          dy;
      longint unsigned len;
      longint unsigned spc;
      longint          samples;
      dx = x1 - x0;
      dy = y1 - y0;
      len = root_floor(dx * dx + dy * dy);
      spc = spacing;
      if (spc == 0) samples = ccc_pkg::MAX_SAMPLES;
      else samples = longint'((len + spc - 1) / spc);
      if (samples < ccc_pkg::MIN_SAMPLES) samples = ccc_pkg::MIN_SAMPLES;
      if (samples > ccc_pkg::MAX_SAMPLES) samples = ccc_pkg::MAX_SAMPLES;
      for (longint i = 0; i <= samples; i++) begin
         if (!probe_point(x0 + (i * dx) / samples, y0 + (i * dy) / samples)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic outcome_type predict_outcome(request_type r);
      outcome_type o;
      o.status = 1'b0;
      o.collision_free = 1'b0;
      case (r.op)
         ccc_pkg::OP_CLEAR: held_count = 0;
         ccc_pkg::OP_LOAD: begin
            if (held_count >= ccc_pkg::MAX_OBSTACLES) begin
               o.status = 1'b1;
            end else begin
               obs_x[held_count] = r.xa;
               obs_y[held_count] = r.ya;
               obs_r[held_count] = r.radius;
               held_count++;
            end
         end
         ccc_pkg::OP_POINT: o.collision_free = probe_point(longint'(r.xa), longint'(r.ya));
         default: o.collision_free = walk_edge(longint'(r.xa), longint'(r.ya),
                                               longint'(r.xb), longint'(r.yb));
      endcase
      o.obstacles_held = ccc_pkg::COUNT_W'(held_count);
      o.queries_so_far = query_total;
      return o;
   endfunction

   function automatic void add_request(ccc_pkg::opcode_type op, int xa, int ya, int xb,
                                       int yb, int radius);
      request_type r;
      r.op = op;
      r.xa = ccc_pkg::COORD_W'(xa);
      r.ya = ccc_pkg::COORD_W'(ya);
      r.xb = ccc_pkg::COORD_W'(xb);
      r.yb = ccc_pkg::COORD_W'(yb);
      r.radius = ccc_pkg::RAD_W'(radius);
      request_q = {request_q, r};
      if (op == ccc_pkg::OP_CLEAR) gen_count = 0;
      else if (op == ccc_pkg::OP_LOAD && gen_count < ccc_pkg::MAX_OBSTACLES) gen_count++;
   endfunction

   function automatic int rand_coord();
      return int'($urandom) <<< 12 >>> 12;
   endfunction

   function automatic int near_unit();
      return $urandom_range(0, 32'h11000) - 32'h800;
   endfunction

   // mostly well-formed traffic inside the unit square, some full-range noise
   function automatic void add_random(int n, int max_len);
      int cap;
      int xa;
      int ya;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         cap = (gen_count > 16) ? max_len / 8 : max_len;
         xa = near_unit();
         ya = near_unit();
         if (sel < 3) begin
            add_request(ccc_pkg::OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), $urandom);
         end else if (sel == 3) begin
            // fill the table and push two loads past full
            for (int k = gen_count; k < ccc_pkg::MAX_OBSTACLES + 2; k++)
               add_request(ccc_pkg::OP_LOAD, near_unit(), near_unit(), rand_coord(),
                           rand_coord(), $urandom_range(0, 32'h800));
         end else if (sel < 30) begin
            add_request(ccc_pkg::OP_LOAD, ($urandom_range(0, 9) == 0) ? rand_coord() : xa,
                        ($urandom_range(0, 9) == 0) ? rand_coord() : ya,
                        rand_coord(), rand_coord(),
                        ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h3000));
         end else if (sel < 60) begin
            if ($urandom_range(0, 9) == 0) begin
               xa = rand_coord();
               ya = rand_coord();
            end
            add_request(ccc_pkg::OP_POINT, xa, ya, rand_coord(), rand_coord(), $urandom);
         end else if (sel < 92) begin
            add_request(ccc_pkg::OP_EDGE, xa, ya, xa + $urandom_range(0, 2 * cap) - cap,
                        ya + $urandom_range(0, 2 * cap) - cap, $urandom);
         end else begin
            // start far outside so the walk ends at once
            add_request(ccc_pkg::OP_EDGE, -524288 + $urandom_range(0, 32'h3FFFF),
                        rand_coord(), rand_coord(), rand_coord(), $urandom);
         end
      end
   endfunction

   // sample between edges so driver updates have settled
   task automatic wait_idle();
      while (request_q.size() != 0 || req_bus.valid || outcome_q.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_spacing(int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= ccc_pkg::SPACING_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      spacing = ccc_pkg::SPACING_W'(value);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) outcome_q = {outcome_q, predict_outcome(cur_req)};
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (request_q.size() > 0) begin
               cur_req = request_q.pop_front();
               req_bus.opcode <= cur_req.op;
               req_bus.x_a <= cur_req.xa;
               req_bus.y_a <= cur_req.ya;
               req_bus.x_b <= cur_req.xb;
               req_bus.y_b <= cur_req.yb;
               req_bus.radius <= cur_req.radius;
               req_bus.valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: response with nothing expected (actual %0d %0d %0d %0d)", $time,
                        rsp_bus.status, rsp_bus.collision_free, rsp_bus.obstacles_held,
                        rsp_bus.queries_so_far);
               failed = 1'b1;
            end else begin
               outcome_type e;
               e = outcome_q.pop_front();
               if (rsp_bus.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_bus.status);
                  failed = 1'b1;
               end
               if (rsp_bus.collision_free !== e.collision_free) begin
                  $display("%0t: collision_free expected %0d actual %0d", $time,
                           e.collision_free, rsp_bus.collision_free);
                  failed = 1'b1;
               end
               if (rsp_bus.obstacles_held !== e.obstacles_held) begin
                  $display("%0t: obstacles_held expected %0d actual %0d", $time,
                           e.obstacles_held, rsp_bus.obstacles_held);
                  failed = 1'b1;
               end
               if (rsp_bus.queries_so_far !== e.queries_so_far) begin
                  $display("%0t: queries_so_far expected %0d actual %0d", $time,
                           e.queries_so_far, rsp_bus.queries_so_far);
                  failed = 1'b1;
               end
            end
         end
         if (ready_left <= 0) begin
            ready_mode = ($urandom_range(0, 3) != 0);
            ready_left = ready_mode ? $urandom_range(1, 40) : $urandom_range(1, 6);
         end
         ready_left--;
         rsp_bus.ready <= ready_mode;
      end
   end

   initial begin
      #1_000_000_000;
      $display("[circle_obstacle_collision_checker_core] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.x_a = '0;
      req_bus.y_a = '0;
      req_bus.x_b = '0;
      req_bus.y_b = '0;
      req_bus.radius = '0;
      rsp_bus.ready = 1'b0;
      failed = 1'b0;
      burst_left = 1;
      gap_left = 0;
      ready_left = 0;
      ready_mode = 1'b1;
      gen_count = 0;
      held_count = 0;
      query_total = '0;
      spacing = ccc_pkg::SPACING_RESET;

      // corners, out-of-square points and coordinate extremes
      add_request(ccc_pkg::OP_POINT, 0, 0, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 65536, 65536, -524288, 524287, 524287);
      add_request(ccc_pkg::OP_POINT, -1, 0, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 65537, 65536, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, -524288, 524287, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 524287, -524288, 0, 0, 0);
      // zero radius blocks only its centre
      add_request(ccc_pkg::OP_LOAD, 32768, 32768, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 32768, 32768, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 32769, 32768, 0, 0, 0);
      add_request(ccc_pkg::OP_EDGE, 32768, 0, 32768, 65536, 0);
      add_request(ccc_pkg::OP_EDGE, 0, 0, 0, 0, 0);
      add_request(ccc_pkg::OP_EDGE, 0, 0, 65536, 65536, 0);
      add_request(ccc_pkg::OP_EDGE, 65536, 65536, 1, 3, 0);
      add_request(ccc_pkg::OP_EDGE, -524288, -524288, 524287, 524287, 0);
      // huge obstacle at a far corner still misses the unit square
      add_request(ccc_pkg::OP_LOAD, -524288, 524287, 0, 0, 524287);
      add_request(ccc_pkg::OP_POINT, 0, 0, 0, 0, 0);
      add_request(ccc_pkg::OP_LOAD, 524287, -524288, 0, 0, 1);
      // clear leaves old entries unread
      add_request(ccc_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      add_request(ccc_pkg::OP_POINT, 32768, 32768, 0, 0, 0);
      add_request(ccc_pkg::OP_EDGE, 0, 65536, 65536, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_random(250, 20000);
      wait_idle();
      write_spacing(65536);
      add_random(160, 200000);
      wait_idle();
      write_spacing(1);
      add_request(ccc_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      add_random(100, 3);
      wait_idle();
      // zero spacing saturates the sample count; start outside to keep it short
      write_spacing(0);
      add_request(ccc_pkg::OP_EDGE, -5, 100, 65536, 65536, 0);
      add_request(ccc_pkg::OP_EDGE, 100, 100, 100, 100, 0);
      add_request(ccc_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
      wait_idle();
      write_spacing($urandom_range(2000, 20000));
      add_random(100, 30000);
      wait_idle();

      if (!failed) begin
         $display("[circle_obstacle_collision_checker_core] OK");
      end else begin
         $display("[circle_obstacle_collision_checker_core] ERROR");
      end
      $finish;
   end

endmodule
